>>> rtl/core/fdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg: shared constants, types and arithmetic helpers
// Widths, register indexes, Q2.14 scaling and saturation for the comb filter.
// ----------------------------------------------------------------------------
package fdc_pkg;

  // Delay line geometry
  localparam int DELAY_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  // Field widths
  localparam int SMP_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int DLEN_W  = 17;
  localparam int STORE_W = 18;

  // Fixed point
  localparam int Q_FRAC  = 14;
  localparam int PROD_W  = GAIN_W + STORE_W;   // one gain times one stored value
  localparam int ACC_W   = PROD_W + 1;         // sum of two such terms
  localparam int QUO_W   = ACC_W - Q_FRAC;     // accumulator after /2^14

  // Length compare width: holds both the 17-bit register and the depth
  localparam int CMP_W = (ADDR_W + 1 > DLEN_W) ? ADDR_W + 1 : DLEN_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DLEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BL_GAIN   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [DLEN_W-1:0]        DLEN_RST = 17'd4410;
  localparam logic signed [GAIN_W-1:0] FB_RST   = -16'sd8192;
  localparam logic signed [GAIN_W-1:0] FF_RST   = 16'sd16384;
  localparam logic signed [GAIN_W-1:0] BL_RST   = 16'sd8192;

  // Saturation bounds, held at quotient width
  localparam logic signed [QUO_W-1:0] STORE_MAX = QUO_W'((2 ** (STORE_W - 1)) - 1);
  localparam logic signed [QUO_W-1:0] STORE_MIN = -QUO_W'(2 ** (STORE_W - 1));
  localparam logic signed [QUO_W-1:0] SMP_MAX   = QUO_W'((2 ** (SMP_W - 1)) - 1);
  localparam logic signed [QUO_W-1:0] SMP_MIN   = -QUO_W'(2 ** (SMP_W - 1));

  // Stage enables from the sequencer to the datapath
  typedef struct packed {
    logic load;      // input transaction taken
    logic mul_en;    // delayed value present, form feedback and feedforward terms
    logic xh_en;     // internal value settled
    logic blend_en;  // output value taken into the output register
  } fdc_ctrl_t;

  // Divide by 2^14, rounding toward zero
  function automatic logic signed [QUO_W-1:0] q14_div(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = a >>> Q_FRAC;
    if (a[ACC_W-1] && (|a[Q_FRAC-1:0])) begin
      s = s + ACC_W'(1);
    end
    return s[QUO_W-1:0];
  endfunction

  function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [QUO_W-1:0] v);
    logic signed [QUO_W-1:0] c;
    c = v;
    if (v > STORE_MAX) begin
      c = STORE_MAX;
    end else if (v < STORE_MIN) begin
      c = STORE_MIN;
    end
    return c[STORE_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] sat_sample(input logic signed [QUO_W-1:0] v);
    logic signed [QUO_W-1:0] c;
    c = v;
    if (v > SMP_MAX) begin
      c = SMP_MAX;
    end else if (v < SMP_MIN) begin
      c = SMP_MIN;
    end
    return c[SMP_W-1:0];
  endfunction

endpackage

>>> rtl/core/fdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_ram: delay line storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fdc_ram (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [fdc_pkg::ADDR_W-1:0]            waddr_i,
  input  logic signed [fdc_pkg::STORE_W-1:0]    wdata_i,
  input  logic                                  re_i,
  input  logic [fdc_pkg::ADDR_W-1:0]            raddr_i,
  output logic signed [fdc_pkg::STORE_W-1:0]    rdata_o
);
  import fdc_pkg::*;

  logic signed [STORE_W-1:0] mem [DELAY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/core/fdc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_dp: comb filter arithmetic
// Feedback/feedforward products, internal value, blend product and output.
// ----------------------------------------------------------------------------
module fdc_dp (
  input  logic                                  clk_i,
  input  fdc_pkg::fdc_ctrl_t                    ctrl_i,
  input  logic signed [fdc_pkg::SMP_W-1:0]      sample_i,
  input  logic signed [fdc_pkg::STORE_W-1:0]    rd_data_i,
  input  logic                                  rd_valid_i,
  input  logic signed [fdc_pkg::GAIN_W-1:0]     fb_gain_i,
  input  logic signed [fdc_pkg::GAIN_W-1:0]     ff_gain_i,
  input  logic signed [fdc_pkg::GAIN_W-1:0]     bl_gain_i,
  output logic signed [fdc_pkg::STORE_W-1:0]    xh_o,
  output logic signed [fdc_pkg::SMP_W-1:0]      y_o
);
  import fdc_pkg::*;

  logic signed [SMP_W-1:0]   x_q;
  logic signed [STORE_W-1:0] d;
  logic signed [PROD_W-1:0]  fb_prod, ff_prod, bl_prod;
  logic signed [ACC_W-1:0]   acc1_d, acc1_q, acc2;
  logic signed [PROD_W-1:0]  ff_prod_q;
  logic signed [STORE_W-1:0] xh_q;

  // never-written entries read as zero
  assign d = rd_valid_i ? rd_data_i : '0;

  assign fb_prod = fb_gain_i * d;
  assign ff_prod = ff_gain_i * d;
  assign acc1_d  = {{(ACC_W - SMP_W - Q_FRAC){x_q[SMP_W-1]}}, x_q, {Q_FRAC{1'b0}}}
                 + {fb_prod[PROD_W-1], fb_prod};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= sample_i;
    end
    if (ctrl_i.mul_en) begin
      acc1_q    <= acc1_d;
      ff_prod_q <= ff_prod;
    end
    if (ctrl_i.xh_en) begin
      xh_q <= xh_o;
    end
  end

  assign xh_o = sat_store(q14_div(acc1_q));

  assign bl_prod = bl_gain_i * xh_q;
  assign acc2    = {ff_prod_q[PROD_W-1], ff_prod_q} + {bl_prod[PROD_W-1], bl_prod};
  assign y_o     = sat_sample(q14_div(acc2));

endmodule

>>> rtl/core/feedback_delay_comb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_delay_comb: universal comb filter with a feedback delay line
// xh = x + fb*d, y = ff*d + bl*xh, d = xh from delay_length samples back.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | in_valid_i / in_ready_o    | sample_in_i  (s16)
//  out     | output    | out_valid_o / out_ready_i  | sample_out_o (s16)
//  cfg     | input     | cfg_we_i (no back-pressure) | cfg_idx_i, cfg_data_i
//
//  Steps: accept + read, multiply, store, blend, in that order; a new input
//  is taken only back in idle, after the blend step. The steps are set by
//  the delay memory read latency and the two dependent multiplications.
//  Reset: config registers return to defaults, write pointer goes to 0; the
//  store is not swept, entries never written read as zero (wrap flag).
//  Stalls: a held output only stops the blend step; the next input is taken
//  while a result waits in the output register.
// ----------------------------------------------------------------------------
module feedback_delay_comb (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [fdc_pkg::SMP_W-1:0]      sample_in_i,
  // output stream
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [fdc_pkg::SMP_W-1:0]      sample_out_o,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import fdc_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_XH    = 2'd2;
  localparam logic [1:0] S_BLEND = 2'd3;

  logic [1:0] state_q, state_d;

  // configuration
  logic [DLEN_W-1:0]        dlen_q;
  logic signed [GAIN_W-1:0] fb_q, ff_q, bl_q;

  // ring pointer and wrap flag: entries below wp_q, or all once wrapped,
  // hold written data
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic              wrapped_q, wrapped_d;

  // read address generation
  logic [CMP_W-1:0]  len_ext, len_eff, depth_c;
  logic [CMP_W:0]    diff;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_hit;
  logic              rd_valid_q;

  logic                      accept;
  logic                      out_free;
  logic                      mem_we;
  fdc_ctrl_t                 ctrl;
  logic signed [STORE_W-1:0] rd_data;
  logic signed [STORE_W-1:0] xh;
  logic signed [SMP_W-1:0]   y;

  logic                      out_valid_q;
  logic signed [SMP_W-1:0]   sample_out_q;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q <= DLEN_RST;
      fb_q   <= FB_RST;
      ff_q   <= FF_RST;
      bl_q   <= BL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELAY_LEN: dlen_q <= cfg_data_i;
        REG_FB_GAIN:   fb_q   <= cfg_data_i[GAIN_W-1:0];
        REG_FF_GAIN:   ff_q   <= cfg_data_i[GAIN_W-1:0];
        REG_BL_GAIN:   bl_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Read address: wp - len modulo depth, len clamped to 1..depth
  // --------------------------------------------------------------------------
  assign depth_c = CMP_W'(DELAY_DEPTH);
  assign len_ext = CMP_W'(dlen_q);

  always_comb begin
    len_eff = len_ext;
    if (len_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > depth_c) begin
      len_eff = depth_c;
    end
  end

  assign diff = {1'b0, CMP_W'(wp_q)} - {1'b0, len_eff};

  always_comb begin
    if (diff[CMP_W]) begin
      rd_addr = ADDR_W'(diff[CMP_W-1:0] + depth_c);
    end else begin
      rd_addr = diff[ADDR_W-1:0];
    end
  end

  // no borrow means the entry lies below wp_q and was written this lap
  assign rd_hit = wrapped_q || !diff[CMP_W];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign mem_we     = (state_q == S_XH);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_MUL;
      S_MUL:   state_d = S_XH;
      S_XH:    state_d = S_BLEND;
      S_BLEND: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load     = accept;
    ctrl.mul_en   = (state_q == S_MUL);
    ctrl.xh_en    = (state_q == S_XH);
    ctrl.blend_en = (state_q == S_BLEND) && out_free;
  end

  // pointer advances with the store write
  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (mem_we) begin
      if (wp_q == ADDR_W'(DELAY_DEPTH - 1)) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      if (accept) begin
        rd_valid_q <= rd_hit;
      end
      if (ctrl.blend_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.blend_en) begin
      sample_out_q <= y;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  // --------------------------------------------------------------------------
  // Delay store and arithmetic
  // --------------------------------------------------------------------------
  fdc_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (xh),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  fdc_dp u_dp (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .sample_i   (sample_in_i),
    .rd_data_i  (rd_data),
    .rd_valid_i (rd_valid_q),
    .fb_gain_i  (fb_q),
    .ff_gain_i  (ff_q),
    .bl_gain_i  (bl_q),
    .xh_o       (xh),
    .y_o        (y)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MUL))
    else $error("accepted transaction did not enter multiply step");

  a_write_advances_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (wp_q != $past(wp_q)))
    else $error("store write did not advance write pointer");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("wrap flag cleared");

  a_out_from_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_BLEND))
    else $error("output valid raised outside blend step");

  a_one_write_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> !mem_we)
    else $error("store written twice for one transaction");

endmodule
